@@ design/spicd_pkg.sv @@
// Shared constants and types for the serial clock divider search.
// No dependencies; imported by the divider, the top level and the checker.
package spicd_pkg;

    localparam int BUS_W   = 27;   // bus clock and every quotient
    localparam int TGT_W   = 32;   // requested frequency
    localparam int DVS_W   = 30;   // divider operand: up to 5 * (2^27 - 1)
    localparam int FIELD_W = 13;   // prescaler register field
    localparam int DIVR_W  = 3;    // post-divisor code
    localparam int HIGH_W  = 2;    // high-phase count

    localparam int PRESCALE_MAX_DEF = 8192;

    localparam logic [BUS_W-1:0]   BUS_RESET = BUS_W'(80000000);
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    localparam logic [DIVR_W-1:0] DIV_TWO   = 3'd2;
    localparam logic [DIVR_W-1:0] DIV_THREE = 3'd3;
    localparam logic [DIVR_W-1:0] DIV_FIVE  = 3'd5;

    typedef struct packed {
        logic             start;
        logic [BUS_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage

@@ design/spicd_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on spicd_pkg for operand widths and the request struct.
module spicd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  spicd_pkg::div_req_t         req,
    output logic                        done,
    output logic [spicd_pkg::BUS_W-1:0] quotient
);
    import spicd_pkg::*;

    localparam int CNT_W = $clog2(BUS_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [BUS_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DVS_W:0]   shifted;
    logic             fits;
    logic [DVS_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[BUS_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg <= '0;
                quo_reg <= req.dividend;
                dvs_reg <= req.divisor;
                cnt_reg <= CNT_W'(BUS_W);
                run_reg <= 1'b1;
            end
            else if (run_reg) begin
                // remainder stays below the divisor, so the low bits suffice
                rem_reg <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[BUS_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/spi_clock_divider_search_unit.sv @@
// Serial clock divider search: picks prescaler and post-divisor for a requested rate.
// Depends on spicd_pkg and spicd_div (shared bit-serial divider).
// A pass-through request shows its result in the cycle after acceptance. Otherwise
// every step is one pass of the shared divider (launch, one bit step per quotient bit,
// collect); a request takes 1, 5 or 11 passes. One request at a time; busy is high
// while a search runs. The result strobe lasts one cycle and cannot stall.
// Reset (rst_n, asynchronous) returns to idle and loads the bus clock with 80 MHz.
module spi_clock_divider_search_unit #(
    parameter int PRESCALE_MAX = spicd_pkg::PRESCALE_MAX_DEF,
    parameter int PRESCALE_W   = $clog2(PRESCALE_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [spicd_pkg::TGT_W-1:0]   target_hz,
    // result channel
    output logic                          done,
    output logic                          pass_through,
    output logic [spicd_pkg::BUS_W-1:0]   actual_hz,
    output logic [PRESCALE_W-1:0]         prescale,
    output logic [spicd_pkg::DIVR_W-1:0]  divisor,
    output logic [spicd_pkg::HIGH_W-1:0]  count_high,
    output logic [spicd_pkg::DIVR_W-1:0]  count_period,
    output logic [spicd_pkg::FIELD_W-1:0] prescale_field,
    output logic                          out_of_range,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import spicd_pkg::*;

    localparam logic REG_BUS_CLOCK = 1'b0;

    typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_WAIT, S_PICK} state_t;
    typedef enum logic [2:0] {OP_NEED, OP_PRE0, OP_M, OP_F, OP_ACT} op_t;

    // Multiply by a post-divisor code: at most three shifted adds.
    function automatic logic [DVS_W-1:0] mul_small(input logic [BUS_W-1:0] x,
                                                   input logic [DIVR_W-1:0] d);
        logic [DVS_W-1:0] xe;
        xe = DVS_W'(x);
        return (d[0] ? xe : '0) + (d[1] ? (xe << 1) : '0) + (d[2] ? (xe << 2) : '0);
    endfunction

    function automatic logic [DIVR_W-1:0] divisor_of(input logic [1:0] k);
        case (k)
            2'd0:    return DIV_TWO;
            2'd1:    return DIV_THREE;
            default: return DIV_FIVE;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [BUS_W-1:0] bus_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUS_CLOCK) ? {{(32 - BUS_W){1'b0}}, bus_reg} : '0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bus_reg <= BUS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_BUS_CLOCK) begin
            bus_reg <= pwdata[BUS_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Search state
    // ---------------------------------------------------------------
    state_t              state_reg;
    op_t                 op_reg;
    logic [1:0]          k_reg;       // 0, 1, 2 for post-divisor 2, 3, 5
    logic                hit_reg;     // divisor 2 hit the request exactly
    logic [BUS_W-1:0]    t_reg;
    logic [BUS_W-1:0]    need_reg;    // smallest prescale * divisor meeting the bound
    logic [BUS_W-1:0]    pre0_reg;    // floor estimate
    logic [BUS_W-1:0]    m_reg;       // need divided by the divisor, rounded up
    logic [BUS_W-1:0]    p_reg [3];
    logic [BUS_W-1:0]    f_reg [3];
    logic [DIVR_W-1:0]   div_reg;
    logic [PRESCALE_W-1:0] pre_sat_reg;
    logic                oor_reg;

    // result registers
    logic                  done_reg;
    logic                  pass_reg;
    logic [BUS_W-1:0]      actual_reg;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic [DIVR_W-1:0]     divisor_reg;
    logic [HIGH_W-1:0]     high_reg;
    logic [DIVR_W-1:0]     period_reg;
    logic [FIELD_W-1:0]    field_reg;
    logic                  oor_out_reg;

    // shared divider
    div_req_t            div_req;
    logic                div_done;
    logic [BUS_W-1:0]    div_quo;

    spicd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [DIVR_W-1:0]     d_cur;
    logic [BUS_W-1:0]      pre0_c;
    logic [BUS_W-1:0]      p_cur;
    logic [1:0]            sel;
    logic [BUS_W-1:0]      pre_sel;
    logic [PRESCALE_W-1:0] field_wide;

    assign d_cur  = divisor_of(k_reg);
    // floor estimate is at least one; take the larger of it and the bound
    assign pre0_c = (pre0_reg == '0) ? BUS_W'(1) : pre0_reg;
    assign p_cur  = (m_reg > pre0_c) ? m_reg : pre0_c;

    // keep divisor 2 unless 3 or 5 is strictly faster; 5 wins a 3/5 tie
    always_comb begin
        if (hit_reg) begin
            sel = 2'd0;
        end
        else if (f_reg[1] > f_reg[0] || f_reg[2] > f_reg[0]) begin
            sel = (f_reg[1] > f_reg[2]) ? 2'd1 : 2'd2;
        end
        else begin
            sel = 2'd0;
        end
    end
    assign pre_sel    = p_reg[sel];
    assign field_wide = pre_sat_reg - 1'b1;

    // operand select for the divider launch
    always_comb begin
        div_req.start    = (state_reg == S_LAUNCH);
        div_req.dividend = bus_reg;
        div_req.divisor  = DVS_W'(t_reg) + 1'b1;
        case (op_reg)
            OP_NEED: div_req.divisor = DVS_W'(t_reg) + 1'b1;
            OP_PRE0: div_req.divisor = mul_small(t_reg, d_cur);
            OP_M:
            begin
                div_req.dividend = need_reg + BUS_W'(d_cur) - 1'b1;
                div_req.divisor  = DVS_W'(d_cur);
            end
            OP_F:    div_req.divisor = mul_small(p_cur, d_cur);
            OP_ACT:  div_req.divisor = mul_small(BUS_W'(pre_sat_reg), div_reg);
            default: div_req.divisor = DVS_W'(t_reg) + 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NEED;
            k_reg     <= 2'd0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start) begin
                        if (target_hz >= TGT_W'(bus_reg)) begin
                            // request at or above the bus clock: pass the bus clock through
                            pass_reg     <= 1'b1;
                            actual_reg   <= bus_reg;
                            prescale_reg <= '0;
                            divisor_reg  <= '0;
                            high_reg     <= '0;
                            period_reg   <= '0;
                            field_reg    <= '0;
                            oor_out_reg  <= 1'b0;
                            done_reg     <= 1'b1;
                        end
                        else if (target_hz == '0) begin
                            // zero request never meets the bound: saturate on divisor 2
                            div_reg     <= DIV_TWO;
                            pre_sat_reg <= PRESCALE_W'(PRESCALE_MAX);
                            oor_reg     <= 1'b1;
                            op_reg      <= OP_ACT;
                            state_reg   <= S_LAUNCH;
                        end
                        else begin
                            t_reg     <= target_hz[BUS_W-1:0];
                            hit_reg   <= 1'b0;
                            k_reg     <= 2'd0;
                            op_reg    <= OP_NEED;
                            state_reg <= S_LAUNCH;
                        end
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done) begin
                        case (op_reg)
                            OP_NEED:
                            begin
                                need_reg  <= div_quo + 1'b1;
                                op_reg    <= OP_PRE0;
                                state_reg <= S_LAUNCH;
                            end
                            OP_PRE0:
                            begin
                                pre0_reg  <= div_quo;
                                op_reg    <= OP_M;
                                state_reg <= S_LAUNCH;
                            end
                            OP_M:
                            begin
                                m_reg     <= div_quo;
                                op_reg    <= OP_F;
                                state_reg <= S_LAUNCH;
                            end
                            OP_F:
                            begin
                                p_reg[k_reg] <= p_cur;
                                f_reg[k_reg] <= div_quo;
                                if (k_reg == 2'd0 && div_quo == t_reg) begin
                                    hit_reg   <= 1'b1;
                                    state_reg <= S_PICK;
                                end
                                else if (k_reg == 2'd2) begin
                                    state_reg <= S_PICK;
                                end
                                else begin
                                    k_reg     <= k_reg + 1'b1;
                                    op_reg    <= OP_PRE0;
                                    state_reg <= S_LAUNCH;
                                end
                            end
                            OP_ACT:
                            begin
                                pass_reg     <= 1'b0;
                                actual_reg   <= div_quo;
                                prescale_reg <= pre_sat_reg;
                                divisor_reg  <= div_reg;
                                high_reg     <= div_reg[DIVR_W-1:1];
                                period_reg   <= div_reg - 1'b1;
                                field_reg    <= (field_wide > PRESCALE_W'(FIELD_MAX)) ?
                                                FIELD_MAX : FIELD_W'(field_wide);
                                oor_out_reg  <= oor_reg;
                                done_reg     <= 1'b1;
                                state_reg    <= S_IDLE;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_PICK:
                begin
                    // choice is made on unsaturated values, then clip the prescaler
                    div_reg <= divisor_of(sel);
                    if (pre_sel > BUS_W'(PRESCALE_MAX)) begin
                        pre_sat_reg <= PRESCALE_W'(PRESCALE_MAX);
                        oor_reg     <= 1'b1;
                    end
                    else begin
                        pre_sat_reg <= pre_sel[PRESCALE_W-1:0];
                        oor_reg     <= 1'b0;
                    end
                    op_reg    <= OP_ACT;
                    state_reg <= S_LAUNCH;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign pass_through   = pass_reg;
    assign actual_hz      = actual_reg;
    assign prescale       = prescale_reg;
    assign divisor        = divisor_reg;
    assign count_high     = high_reg;
    assign count_period   = period_reg;
    assign prescale_field = field_reg;
    assign out_of_range   = oor_out_reg;

endmodule

@@ design/spicd_check.sv @@
// Port-level checks for the serial clock divider search, bound to the top level.
// Depends on spicd_pkg for the post-divisor codes.
module spicd_check #(
    parameter int PRESCALE_W = 14
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          pass_through,
    input logic [PRESCALE_W-1:0]         prescale,
    input logic [spicd_pkg::DIVR_W-1:0]  divisor,
    input logic [spicd_pkg::DIVR_W-1:0]  count_period,
    input logic                          out_of_range
);
    import spicd_pkg::*;

    // an accepted request is either answered at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request accepted without progress");

    // a search result comes out as busy drops
    a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_pass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pass_through) |-> (prescale == '0 && divisor == '0 && !out_of_range))
        else $error("pass-through result with nonzero settings");

    a_div_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pass_through) |->
            ((divisor == DIV_TWO || divisor == DIV_THREE || divisor == DIV_FIVE)
             && count_period == divisor - 1'b1 && prescale != '0))
        else $error("inconsistent divider settings");

endmodule

bind spi_clock_divider_search_unit spicd_check #(.PRESCALE_W(PRESCALE_W)) u_check (.*);

@@ tb/spi_clock_divider_search_unit_tb.sv @@
// Self-checking bench for spi_clock_divider_search_unit: directed and random rate requests
// under several bus clock settings, each result checked field by field. Depends on spicd_pkg.
module spi_clock_divider_search_unit_tb;
    import spicd_pkg::*;

    localparam int PRESCALE_LIMIT = PRESCALE_MAX_DEF;
    localparam int PRE_W          = $clog2(PRESCALE_LIMIT + 1);

    // Register map: the bus clock is the only register; the next word is unmapped.
    localparam logic [2:0] BUS_CLOCK_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR     = 3'd4;

    localparam logic [BUS_W-1:0] BUS_TOP = '1;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 400;   // longer than the slowest request

    // One result of the search, laid out in port order.
    typedef struct packed {
        logic                 pass_through;
        logic [BUS_W-1:0]     actual_hz;
        logic [PRE_W-1:0]     prescale;
        logic [DIVR_W-1:0]    divisor;
        logic [HIGH_W-1:0]    count_high;
        logic [DIVR_W-1:0]    count_period;
        logic [FIELD_W-1:0]   prescale_field;
        logic                 out_of_range;
    } clock_setting_t;

    // Holds a private copy of the bus clock, predicts the setting for every accepted
    // request and checks the results against them in order.
    class divider_scoreboard;
        logic [BUS_W-1:0] bus_hz;
        clock_setting_t   expected_settings[$];
        logic [31:0]      expected_targets[$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      n_pass;
        int unsigned      n_sat;
        int unsigned      n_div2;
        int unsigned      n_div3;
        int unsigned      n_div5;

        function new();
            bus_hz = BUS_RESET;
        endfunction

        function int pending();
            return expected_settings.size();
        endfunction

        // Smallest prescaler, at least the floor estimate and at least 1, whose output
        // does not exceed the target.
        function longint unsigned least_prescale(longint unsigned bus, longint unsigned t,
                                                 longint unsigned d);
            longint unsigned floor_pre;
            longint unsigned need;
            longint unsigned m;
            if (t == 0)
                return bus + PRESCALE_LIMIT + 1;
            floor_pre = bus / (t * d);
            if (floor_pre == 0)
                floor_pre = 1;
            need = bus / (t + 1) + 1;
            m = (need + d - 1) / d;
            return (m > floor_pre) ? m : floor_pre;
        endfunction

        function clock_setting_t predict_setting(logic [31:0] target);
            clock_setting_t  r;
            longint unsigned bus;
            longint unsigned t;
            longint unsigned p2, p3, p5, f2, f3, f5, pre, field;
            logic [DIVR_W-1:0] code;
            r   = '0;
            bus = bus_hz;
            t   = target;
            if (t >= bus) begin
                r.pass_through = 1'b1;
                r.actual_hz    = bus_hz;
                return r;
            end
            p2   = least_prescale(bus, t, DIV_TWO);
            f2   = bus / (p2 * DIV_TWO);
            pre  = p2;
            code = DIV_TWO;
            // an exact hit on divisor 2 is kept without looking further
            if (f2 != t) begin
                p3 = least_prescale(bus, t, DIV_THREE);
                p5 = least_prescale(bus, t, DIV_FIVE);
                f3 = bus / (p3 * DIV_THREE);
                f5 = bus / (p5 * DIV_FIVE);
                if (f3 > f2 || f5 > f2) begin
                    if (f3 > f5) begin
                        pre  = p3;
                        code = DIV_THREE;
                    end
                    else begin
                        pre  = p5;
                        code = DIV_FIVE;
                    end
                end
            end
            // the choice is made before saturation; the frequency uses the clipped value
            if (pre > PRESCALE_LIMIT) begin
                pre            = PRESCALE_LIMIT;
                r.out_of_range = 1'b1;
            end
            field = pre - 1;
            if (field > FIELD_MAX)
                field = FIELD_MAX;
            r.actual_hz      = BUS_W'(bus / (pre * code));
            r.prescale       = PRE_W'(pre);
            r.divisor        = code;
            r.count_high     = HIGH_W'(code / 2);
            r.count_period   = code - 1'b1;
            r.prescale_field = FIELD_W'(field);
            return r;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        function void note_request(logic [31:0] target);
            expected_settings.push_back(predict_setting(target));
            expected_targets.push_back(target);
        endfunction

        task check_result(clock_setting_t got);
            clock_setting_t want;
            logic [31:0]    target;
            string          bad;
            if (expected_settings.size() == 0) begin
                report($sformatf("result %h with no request outstanding", got));
                return;
            end
            want   = expected_settings.pop_front();
            target = expected_targets.pop_front();
            bad    = "";
            checked++;
            if (want.pass_through)
                n_pass++;
            else begin
                if (want.out_of_range)
                    n_sat++;
                if (want.divisor == DIV_TWO)
                    n_div2++;
                else if (want.divisor == DIV_THREE)
                    n_div3++;
                else
                    n_div5++;
            end
            if (got.pass_through !== want.pass_through)
                bad = {bad, $sformatf(" pass_through %b/%b", got.pass_through,
                                      want.pass_through)};
            if (got.actual_hz !== want.actual_hz)
                bad = {bad, $sformatf(" actual_hz %0d/%0d", got.actual_hz, want.actual_hz)};
            if (got.prescale !== want.prescale)
                bad = {bad, $sformatf(" prescale %0d/%0d", got.prescale, want.prescale)};
            if (got.divisor !== want.divisor)
                bad = {bad, $sformatf(" divisor %0d/%0d", got.divisor, want.divisor)};
            if (got.count_high !== want.count_high)
                bad = {bad, $sformatf(" count_high %0d/%0d", got.count_high,
                                      want.count_high)};
            if (got.count_period !== want.count_period)
                bad = {bad, $sformatf(" count_period %0d/%0d", got.count_period,
                                      want.count_period)};
            if (got.prescale_field !== want.prescale_field)
                bad = {bad, $sformatf(" prescale_field %0d/%0d", got.prescale_field,
                                      want.prescale_field)};
            if (got.out_of_range !== want.out_of_range)
                bad = {bad, $sformatf(" out_of_range %b/%b", got.out_of_range,
                                      want.out_of_range)};
            if (bad != "")
                report($sformatf("target %0d bus %0d (got/expected):%s", target, bus_hz, bad));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [TGT_W-1:0]       target_hz;
    logic                   done;
    logic                   pass_through;
    logic [BUS_W-1:0]       actual_hz;
    logic [PRE_W-1:0]       prescale;
    logic [DIVR_W-1:0]      divisor;
    logic [HIGH_W-1:0]      count_high;
    logic [DIVR_W-1:0]      count_period;
    logic [FIELD_W-1:0]     prescale_field;
    logic                   out_of_range;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    clock_setting_t    seen;
    divider_scoreboard sb;
    int unsigned       n_settings;
    logic              no_idle;   // set for the stretch that runs back to back

    spi_clock_divider_search_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .target_hz      (target_hz),
        .done           (done),
        .pass_through   (pass_through),
        .actual_hz      (actual_hz),
        .prescale       (prescale),
        .divisor        (divisor),
        .count_high     (count_high),
        .count_period   (count_period),
        .prescale_field (prescale_field),
        .out_of_range   (out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run (every request at its longest search
    // plus the longest sender gap), so only a hang gets here.
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    assign seen = {pass_through, actual_hz, prescale, divisor, count_high, count_period,
                   prescale_field, out_of_range};

    // Results cannot be held off: take every strobe at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(seen);
    end

    // Present one request and hold it until the edge where busy is low accepts it.
    // Call in the step right after a rising edge; return in the step of acceptance.
    task automatic request(logic [31:0] t);
        start     <= 1'b1;
        target_hz <= t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(t);
    endtask

    // Occasionally drop start and stay quiet for a while so gaps land anywhere in a search.
    task automatic maybe_idle();
        int unsigned gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 9)
            gap = $urandom_range(1, 330);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every expected result has come and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == BUS_CLOCK_ADDR)
            sb.bus_hz = data[BUS_W-1:0];
    endtask

    task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain, load a new bus clock (junk in the unused upper bits), poke the unmapped
    // word, and read the register back.
    task automatic retune_bus(logic [BUS_W-1:0] hz);
        logic [31:0] rd;
        drain();
        apb_write(BUS_CLOCK_ADDR, {5'($urandom), hz});
        @(posedge clk);
        apb_write(SPARE_ADDR, $urandom);
        @(posedge clk);
        apb_read(BUS_CLOCK_ADDR, rd);
        if (rd !== {{(32 - BUS_W){1'b0}}, hz})
            sb.report($sformatf("bus clock read back %h, wrote %h", rd, hz));
        @(posedge clk);
        n_settings++;
    endtask

    // Random target shaped around the current bus clock: exact and near-exact hits,
    // the pass-through boundary, tiny targets that saturate, and raw 32-bit values.
    function automatic logic [31:0] pick_target(logic [BUS_W-1:0] bus);
        int unsigned b;
        int unsigned p;
        int unsigned d;
        logic [31:0] t;
        b = bus;
        case ($urandom_range(0, 9))
            0: t = $urandom;
            1: t = b + $urandom_range(0, 2);
            2, 3: t = $urandom_range(0, b - 1);
            4, 5: t = $urandom >> $urandom_range(4, 31);
            6, 7:
            begin
                p = $urandom_range(1, 9000);
                case ($urandom_range(0, 2))
                    0: d = DIV_TWO;
                    1: d = DIV_THREE;
                    default: d = DIV_FIVE;
                endcase
                t = b / (p * d) + $urandom_range(0, 2) - 1;
            end
            8: t = b - 1 - $urandom_range(0, 2);
            default: t = $urandom_range(0, 1) ? 32'd0 : b / 2;
        endcase
        return t;
    endfunction

    initial
    begin
        logic [31:0]      directed_reset[$];
        logic [BUS_W-1:0] bus;
        int unsigned      n_items;

        sb         = new();
        n_settings = 0;
        no_idle    = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        target_hz  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // hold reset, then release it once for the whole run
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset bus clock of 80 MHz. Zero request, smallest request, exact hits
        // on each divisor, a 3/5 tie, the saturation edge, the pass-through edge and the
        // largest request.
        directed_reset = '{32'd0, 32'd1, 32'd40000000, 32'd26666666, 32'd16000000,
                           32'd5333333, 32'd4882, 32'd4883, 32'd79999999, 32'd80000000,
                           32'hFFFF_FFFF};
        foreach (directed_reset[i])
            request(directed_reset[i]);

        // zero bus clock: everything passes through with a zero rate
        retune_bus('0);
        request(32'd0);
        request(32'd1);
        request(32'hFFFF_FFFF);

        // one hertz bus clock: only the zero request runs a search
        retune_bus(BUS_W'(1));
        request(32'd0);
        request(32'd1);

        // largest bus clock
        retune_bus(BUS_TOP);
        request(32'(BUS_TOP) - 1);
        request(32'(BUS_TOP));
        request(32'd44739242);
        request(32'd1);
        request(32'd0);

        // Random phases, each under its own bus clock; the reset value and the extremes come first.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: bus = BUS_RESET;
                1: bus = BUS_TOP;
                2: bus = BUS_W'(1);
                3: bus = BUS_W'($urandom_range(2, 1000));
                4: bus = BUS_W'($urandom_range(1000, 1 << 20));
                default: bus = BUS_W'($urandom_range(1, 32'(BUS_TOP)));
            endcase
            retune_bus(bus);
            n_items = (bus < 16) ? 40 : 210;
            // run one phase back to back with no gaps at all
            no_idle = (ph == 5);
            for (int i = 0; i < n_items; i++) begin
                if (i == n_items / 2 && ph == 1)
                    drain();   // pause the sender until every result is back
                else
                    maybe_idle();
                request(pick_target(bus));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d bus clock settings: %0d pass-through,",
                 sb.checked, n_settings + 1, sb.n_pass);
        $display("  %0d saturated prescalers, divisor 2/3/5 chosen %0d/%0d/%0d times.",
                 sb.n_sat, sb.n_div2, sb.n_div3, sb.n_div5);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/spicd_pkg.sv
design/spicd_div.sv
design/spi_clock_divider_search_unit.sv
design/spicd_check.sv
tb/spi_clock_divider_search_unit_tb.sv
